@@ sv/psc_pkg.sv @@
package psc_pkg;

  // item commands
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_BUTTON = 3'd1;
  localparam logic [2:0] CMD_REMOTE = 3'd2;
  localparam logic [2:0] CMD_TRIP   = 3'd3;
  localparam logic [2:0] CMD_WRITE  = 3'd4;

  // result event codes
  localparam logic [3:0] EV_NONE      = 4'd0;
  localparam logic [3:0] EV_START     = 4'd1;
  localparam logic [3:0] EV_STOP      = 4'd2;
  localparam logic [3:0] EV_UNTRUSTED = 4'd3;
  localparam logic [3:0] EV_CUTOFF    = 4'd4;
  localparam logic [3:0] EV_BLOCK     = 4'd5;
  localparam logic [3:0] EV_LATCH_CLR = 4'd6;
  localparam logic [3:0] EV_DEBOUNCED = 4'd7;
  localparam logic [3:0] EV_MOTOR     = 4'd8;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_RUNTIME = 2'd0;
  localparam logic [1:0] CFG_SCHED_COUNT = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE    = 2'd2;

  localparam int CFG_DATA_W = 11;

  // configuration reset values
  localparam logic [10:0] MAX_RUNTIME_RST = 11'd60;
  localparam logic [4:0]  SCHED_COUNT_RST = 5'd0;
  localparam logic [9:0]  DEBOUNCE_RST    = 10'd200;

  // wall clock at or below this is treated as unknown
  localparam logic [31:0] UNIX_VALID_MIN = 32'd1000000000;
  localparam logic [16:0] SECS_PER_MIN   = 17'd60;

  // enabled flag plus sequence id per schedule slot
  localparam int FLAGS_W = 17;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] now_unix;
    logic        time_trusted;
    logic [31:0] now_ms;
    logic        motor_request;
    logic [3:0]  entry_index;
    logic [31:0] entry_start;
    logic [31:0] entry_stop;
    logic        entry_valid;
    logic        entry_enabled;
    logic [15:0] entry_seq;
  } in_item_t;

  typedef struct packed {
    logic        motor_on;
    logic        schedule_active;
    logic [3:0]  active_slot;
    logic [3:0]  event_res;
    logic [15:0] event_seq;
    logic        block_expired;
    logic        fault;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic sel_active;
    logic act;
    logic scan_adv;
    logic scan;
    logic run;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic scan_go;
    logic scan_done;
    logic out_free;
  } ctrl_status_t;

endpackage

@@ sv/psc_ram.sv @@
module psc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/psc_ctrl.sv @@
module psc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  psc_pkg::ctrl_status_t status,
  output psc_pkg::ctrl_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACT  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // sequencing and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready       = 1'b1;
        cmd.sel_active = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ACT;
        end
      end
      S_ACT: begin
        cmd.act = 1'b1;
        if (status.scan_go) begin
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN;
        end else if (status.is_tick) begin
          state_next = S_RUN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_next = S_RUN;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_RUN: begin
        cmd.run    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/psc_dp.sv @@
module psc_dp #(
  parameter int MAX_SCHEDULES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  psc_pkg::in_item_t                   in_item,
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  psc_pkg::ctrl_cmd_t                  cmd,
  output psc_pkg::ctrl_status_t               status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output psc_pkg::out_item_t                  out_item
);

  localparam int IDX_W = (MAX_SCHEDULES > 1) ? $clog2(MAX_SCHEDULES) : 1;

  // configuration registers
  logic [10:0] max_runtime;
  logic [4:0]  sched_count;
  logic [9:0]  debounce;

  // item and controller state
  psc_pkg::in_item_t item;
  logic              motor;
  logic              motor_next;
  logic [31:0]       on_since;
  logic [31:0]       on_since_next;
  logic              active_valid;
  logic              active_valid_next;
  logic [IDX_W-1:0]  active_index;
  logic [IDX_W-1:0]  active_index_next;
  logic [31:0]       block_until;
  logic [31:0]       block_until_next;
  logic              latched;
  logic              latched_next;
  logic [31:0]       last_press;
  logic [31:0]       last_press_next;

  // result under construction
  logic [3:0]  ev;
  logic [3:0]  ev_next;
  logic [15:0] seq;
  logic [15:0] seq_next;
  logic        expired;
  logic        expired_next;
  logic        fault;
  logic        fault_next;

  // schedule table access
  logic [MAX_SCHEDULES-1:0]     sched_valid;
  logic [IDX_W-1:0]             scan_idx;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             rd_idx;
  logic [31:0]                  rd_start;
  logic [31:0]                  rd_stop;
  logic [psc_pkg::FLAGS_W-1:0]  rd_flags;
  logic                         wr_en;
  logic                         wr_in_range;
  logic [IDX_W-1:0]             wr_addr;

  // derived values
  logic [31:0] on_value;
  logic [31:0] n_eff;
  logic        slot_hit;
  logic [31:0] run_secs;
  logic [16:0] run_limit;
  logic        cutoff;
  logic        new_motor;

  assign rd_addr     = cmd.sel_active ? active_index : scan_idx;
  assign wr_in_range = 32'(item.entry_index) < 32'(MAX_SCHEDULES);
  assign wr_addr     = IDX_W'(item.entry_index);
  assign wr_en       = cmd.act && (item.command == psc_pkg::CMD_WRITE) && wr_in_range;

  // schedule table memories
  psc_ram #(.WIDTH(32), .DEPTH(MAX_SCHEDULES)) u_start_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item.entry_start),
    .raddr (rd_addr),
    .rdata (rd_start)
  );

  psc_ram #(.WIDTH(32), .DEPTH(MAX_SCHEDULES)) u_stop_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item.entry_stop),
    .raddr (rd_addr),
    .rdata (rd_stop)
  );

  psc_ram #(.WIDTH(psc_pkg::FLAGS_W), .DEPTH(MAX_SCHEDULES)) u_flags_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata ({item.entry_seq, item.entry_enabled}),
    .raddr (rd_addr),
    .rdata (rd_flags)
  );

  // on time to record when the motor comes on
  assign on_value = (item.now_unix > psc_pkg::UNIX_VALID_MIN) ? item.now_unix : 32'd0;

  // scanned slot count, capped at the table size
  assign n_eff = (32'(sched_count) > 32'(MAX_SCHEDULES)) ? 32'(MAX_SCHEDULES)
                                                          : 32'(sched_count);

  // due check on the slot read last cycle
  assign slot_hit = sched_valid[rd_idx] && rd_flags[0] &&
                    (item.now_unix >= rd_start) && (item.now_unix < rd_stop);

  // runtime limit compared in seconds
  assign run_secs  = item.now_unix - on_since;
  assign run_limit = 17'(max_runtime) * psc_pkg::SECS_PER_MIN;
  assign cutoff    = motor && (on_since != 32'd0) && (run_secs >= 32'(run_limit));
  assign new_motor = !motor;

  // next state for each phase of an item
  always_comb begin
    motor_next        = motor;
    on_since_next     = on_since;
    active_valid_next = active_valid;
    active_index_next = active_index;
    block_until_next  = block_until;
    latched_next      = latched;
    last_press_next   = last_press;
    ev_next           = ev;
    seq_next          = seq;
    expired_next      = expired;
    fault_next        = fault;

    if (cmd.capture) begin
      ev_next      = psc_pkg::EV_NONE;
      seq_next     = 16'd0;
      expired_next = 1'b0;
      fault_next   = 1'b0;
    end

    // first phase, with the active slot read back
    if (cmd.act) begin
      case (item.command)
        psc_pkg::CMD_TICK: begin
          if (!item.time_trusted) begin
            if (active_valid) begin
              seq_next          = rd_flags[16:1];
              ev_next           = psc_pkg::EV_UNTRUSTED;
              fault_next        = 1'b1;
              motor_next        = 1'b0;
              on_since_next     = 32'd0;
              active_valid_next = 1'b0;
            end
          end else begin
            if ((block_until != 32'd0) && (item.now_unix >= block_until)) begin
              block_until_next = 32'd0;
              expired_next     = 1'b1;
            end
            if (active_valid && (item.now_unix >= rd_stop)) begin
              seq_next          = rd_flags[16:1];
              ev_next           = psc_pkg::EV_STOP;
              motor_next        = 1'b0;
              on_since_next     = 32'd0;
              active_valid_next = 1'b0;
            end
          end
        end
        psc_pkg::CMD_BUTTON: begin
          if ((item.now_ms - last_press) > 32'(debounce)) begin
            last_press_next = item.now_ms;
            if (latched) begin
              latched_next = 1'b0;
              ev_next      = psc_pkg::EV_LATCH_CLR;
            end else begin
              motor_next    = new_motor;
              on_since_next = new_motor ? on_value : 32'd0;
              ev_next       = psc_pkg::EV_MOTOR;
              if (!new_motor && active_valid) begin
                block_until_next  = rd_stop;
                seq_next          = rd_flags[16:1];
                active_valid_next = 1'b0;
                ev_next           = psc_pkg::EV_BLOCK;
              end
            end
          end else begin
            ev_next = psc_pkg::EV_DEBOUNCED;
          end
        end
        psc_pkg::CMD_REMOTE: begin
          if (!(item.motor_request && latched) && (item.motor_request != motor)) begin
            motor_next    = item.motor_request;
            on_since_next = item.motor_request ? on_value : 32'd0;
            ev_next       = psc_pkg::EV_MOTOR;
          end
        end
        psc_pkg::CMD_TRIP: begin
          latched_next      = 1'b1;
          active_valid_next = 1'b0;
          if (motor) begin
            motor_next    = 1'b0;
            on_since_next = 32'd0;
            ev_next       = psc_pkg::EV_MOTOR;
          end
        end
        default: begin
        end
      endcase
    end

    // schedule start on the first due slot
    if (cmd.scan && slot_hit) begin
      seq_next          = rd_flags[16:1];
      ev_next           = psc_pkg::EV_START;
      motor_next        = 1'b1;
      on_since_next     = on_value;
      active_valid_next = 1'b1;
      active_index_next = rd_idx;
    end

    // maximum runtime enforcement
    if (cmd.run && cutoff) begin
      ev_next           = psc_pkg::EV_CUTOFF;
      seq_next          = 16'd0;
      fault_next        = 1'b1;
      motor_next        = 1'b0;
      on_since_next     = 32'd0;
      active_valid_next = 1'b0;
      block_until_next  = 32'd0;
    end
  end

  // status to the controller
  // a scan runs only when no schedule was active at the start of the tick
  assign status.is_tick   = item.command == psc_pkg::CMD_TICK;
  assign status.scan_go   = (item.command == psc_pkg::CMD_TICK) && item.time_trusted &&
                            !active_valid && !latched && !motor &&
                            ((block_until == 32'd0) || (item.now_unix >= block_until)) &&
                            (n_eff != 32'd0);
  assign status.scan_done = slot_hit || ((32'(rd_idx) + 32'd1) >= n_eff);
  assign status.out_free  = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_runtime <= psc_pkg::MAX_RUNTIME_RST;
      sched_count <= psc_pkg::SCHED_COUNT_RST;
      debounce    <= psc_pkg::DEBOUNCE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        psc_pkg::CFG_MAX_RUNTIME: max_runtime <= cfg_data;
        psc_pkg::CFG_SCHED_COUNT: sched_count <= cfg_data[4:0];
        psc_pkg::CFG_DEBOUNCE:    debounce    <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  // controller state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      motor        <= 1'b0;
      on_since     <= 32'd0;
      active_valid <= 1'b0;
      active_index <= '0;
      block_until  <= 32'd0;
      latched      <= 1'b0;
      last_press   <= 32'd0;
      sched_valid  <= '0;
      out_valid    <= 1'b0;
    end else begin
      motor        <= motor_next;
      on_since     <= on_since_next;
      active_valid <= active_valid_next;
      active_index <= active_index_next;
      block_until  <= block_until_next;
      latched      <= latched_next;
      last_press   <= last_press_next;
      if (wr_en) begin
        sched_valid[wr_addr] <= item.entry_valid;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, scan pointer and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= in_item;
      scan_idx <= '0;
    end else if (cmd.scan_adv) begin
      scan_idx <= scan_idx + 1'b1;
    end
    rd_idx  <= rd_addr;
    ev      <= ev_next;
    seq     <= seq_next;
    expired <= expired_next;
    fault   <= fault_next;
    if (cmd.load_out) begin
      out_item.motor_on        <= motor;
      out_item.schedule_active <= active_valid;
      out_item.active_slot     <= active_valid ? 4'(active_index) : 4'd0;
      out_item.event_res       <= ev;
      out_item.event_seq       <= seq;
      out_item.block_expired   <= expired;
      out_item.fault           <= fault;
    end
  end

endmodule

@@ sv/pump_schedule_safety_controller.sv @@
// channel | signals                          | accepted when
// in      | in_valid, in_ready, in_item      | in_valid && in_ready
// out     | out_valid, out_ready, out_item   | out_valid && out_ready
// cfg     | cfg_write, cfg_index, cfg_data   | cfg_write
//
// a button, remote set, trip or table write passes the act and done states;
// a tick passes act, scan (when a start can occur), run and done. the scan
// steps one slot per read of the table memories, up to the scan count.
// one item is worked at a time; the result register lets the next item enter
// while the last result still waits on out_ready.
// synchronous reset clears motor state, latch, block and all slot valid bits.
module pump_schedule_safety_controller #(
  parameter int MAX_SCHEDULES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  psc_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output psc_pkg::out_item_t             out_item,
  input  logic                           cfg_write,
  input  logic [1:0]                     cfg_index,
  input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_data
);

  psc_pkg::ctrl_cmd_t    cmd;
  psc_pkg::ctrl_status_t status;

  // sequencer
  psc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // state, schedule table and result register
  psc_dp #(.MAX_SCHEDULES(MAX_SCHEDULES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
